[rtl/core/chacha20_double_round_assert.svh]
// Assertion macros for the ChaCha double round core.
`ifndef CHACHA20_DOUBLE_ROUND_ASSERT_SVH
`define CHACHA20_DOUBLE_ROUND_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define CHDR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chdr assertion failed");
// Next-cycle implication.
`define CHDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chdr assertion failed");
`else
`define CHDR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CHDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/chdr_pkg.sv]
// Types and round functions for the ChaCha double round core.
`timescale 1ns / 1ps
`default_nettype none

package chdr_pkg;

   localparam int unsigned WordBits  = 32;
   localparam int unsigned NumStages = 4;
   localparam int unsigned RotA      = 16;
   localparam int unsigned RotB      = 12;
   localparam int unsigned RotC      = 8;
   localparam int unsigned RotD      = 7;

   typedef logic [WordBits-1:0] word_type;
   typedef word_type [15:0]     state_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   // rotate left by a constant amount
   function automatic word_type rotl(word_type x, int unsigned r);
      return (x << r) | (x >> (WordBits - r));
   endfunction

   // one half of a quarter round: two adds, two xor-rotates
   function automatic quad_type qr_half(quad_type q, int unsigned r1, int unsigned r2);
      quad_type o;
      o   = q;
      o.a = o.a + o.b;
      o.d = rotl(o.d ^ o.a, r1);
      o.c = o.c + o.d;
      o.b = rotl(o.b ^ o.c, r2);
      return o;
   endfunction

   // half of a column or diagonal round over all four lanes
   function automatic state_type round_half(state_type s, logic diag, logic second);
      state_type   o;
      quad_type    q;
      logic [1:0]  lane;
      logic [1:0]  off;
      logic [3:0]  ia;
      logic [3:0]  ib;
      logic [3:0]  ic;
      logic [3:0]  id;
      o = s;
      for (int i = 0; i < 4; i++) begin
         lane = 2'(i);
         off  = {1'b0, diag};
         ia   = {2'd0, lane};
         ib   = {2'd1, 2'(lane + off)};
         ic   = {2'd2, 2'(lane + (off << 1))};
         id   = {2'd3, 2'(lane + off + (off << 1))};
         q.a  = s[ia];
         q.b  = s[ib];
         q.c  = s[ic];
         q.d  = s[id];
         if (second) begin
            q = qr_half(q, RotC, RotD);
         end else begin
            q = qr_half(q, RotA, RotB);
         end
         o[ia] = q.a;
         o[ib] = q.b;
         o[ic] = q.c;
         o[id] = q.d;
      end
      return o;
   endfunction

endpackage

`default_nettype wire

[rtl/core/chacha20_double_round.sv]
// ChaCha double round core: four-stage pipeline, one state per cycle while rsp is not stalled.
`timescale 1ns / 1ps
`default_nettype none

//  channel | ports                         | direction | transaction moves
//  req     | req_valid, req_stall, req_*   | in        | 16-word state, 8 x 64 bits
//  rsp     | rsp_valid, rsp_stall, rsp_*   | out       | new state after one double round
//
//  rsp_valid rises once the req transaction has been registered in each stage
//  in turn; throughput is one transaction per cycle while rsp is not stalled.
//  Each stage does half of four parallel quarter rounds (two dependent 32-bit
//  adds): column first half, column second half, diagonal first half, diagonal
//  second half. The last stage is the output register. Reset clears the stage
//  valid bits only. rsp_stall backs up stage by stage; empty stages still fill,
//  so req_stall rises only when all four stages hold a transaction and the
//  output is stalled.

module chacha20_double_round (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_row0_words01,
   input  wire logic [63:0] req_row0_words23,
   input  wire logic [63:0] req_row1_words45,
   input  wire logic [63:0] req_row1_words67,
   input  wire logic [63:0] req_row2_words89,
   input  wire logic [63:0] req_row2_words1011,
   input  wire logic [63:0] req_row3_words1213,
   input  wire logic [63:0] req_row3_words1415,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_out_words01,
   output logic [63:0]      rsp_out_words23,
   output logic [63:0]      rsp_out_words45,
   output logic [63:0]      rsp_out_words67,
   output logic [63:0]      rsp_out_words89,
   output logic [63:0]      rsp_out_words1011,
   output logic [63:0]      rsp_out_words1213,
   output logic [63:0]      rsp_out_words1415
);

   localparam int unsigned Last = chdr_pkg::NumStages - 1;

   chdr_pkg::state_type                  req_state;
   chdr_pkg::state_type                  stage_state_in [chdr_pkg::NumStages];
   chdr_pkg::state_type                  stage_state_ff [chdr_pkg::NumStages];
   logic [chdr_pkg::NumStages-1:0]       stage_valid_ff;
   logic [chdr_pkg::NumStages-1:0]       stage_valid_in;
   logic [chdr_pkg::NumStages-1:0]       advance;

   // words packed low-numbered in the low half
   assign req_state = {req_row3_words1415, req_row3_words1213,
                       req_row2_words1011, req_row2_words89,
                       req_row1_words67,   req_row1_words45,
                       req_row0_words23,   req_row0_words01};

   // round halves, one per stage
   always_comb begin
      stage_state_in[0] = chdr_pkg::round_half(req_state,         1'b0, 1'b0);
      stage_state_in[1] = chdr_pkg::round_half(stage_state_ff[0], 1'b0, 1'b1);
      stage_state_in[2] = chdr_pkg::round_half(stage_state_ff[1], 1'b1, 1'b0);
      stage_state_in[3] = chdr_pkg::round_half(stage_state_ff[2], 1'b1, 1'b1);
   end

   // a stage loads when it is empty or its content moves on
   always_comb begin
      advance[Last] = !stage_valid_ff[Last] || !rsp_stall;
      for (int k = Last - 1; k >= 0; k--) begin
         advance[k] = !stage_valid_ff[k] || advance[k+1];
      end
      stage_valid_in = {stage_valid_ff[Last-1:0], req_valid};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < chdr_pkg::NumStages; k++) begin
         if (advance[k]) begin
            stage_state_ff[k] <= stage_state_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         for (int k = 0; k < chdr_pkg::NumStages; k++) begin
            if (advance[k]) begin
               stage_valid_ff[k] <= stage_valid_in[k];
            end
         end
      end
   end

   assign req_stall         = !advance[0];
   assign rsp_valid         = stage_valid_ff[Last];
   assign rsp_out_words01   = {stage_state_ff[Last][1],  stage_state_ff[Last][0]};
   assign rsp_out_words23   = {stage_state_ff[Last][3],  stage_state_ff[Last][2]};
   assign rsp_out_words45   = {stage_state_ff[Last][5],  stage_state_ff[Last][4]};
   assign rsp_out_words67   = {stage_state_ff[Last][7],  stage_state_ff[Last][6]};
   assign rsp_out_words89   = {stage_state_ff[Last][9],  stage_state_ff[Last][8]};
   assign rsp_out_words1011 = {stage_state_ff[Last][11], stage_state_ff[Last][10]};
   assign rsp_out_words1213 = {stage_state_ff[Last][13], stage_state_ff[Last][12]};
   assign rsp_out_words1415 = {stage_state_ff[Last][15], stage_state_ff[Last][14]};

`include "chacha20_double_round_assert.svh"

   // an accepted transaction always lands in the first stage
   `CHDR_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && !req_stall, stage_valid_ff[0])
   // back-pressure on req only with a full pipe and a stalled output
   `CHDR_ASSERT_IMPL(a_stall_full, clock, reset, req_stall, (&stage_valid_ff) && rsp_stall)
   // a taken result with nothing behind it leaves the output empty
   `CHDR_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !stage_valid_ff[Last-1], !rsp_valid)

endmodule

`default_nettype wire

[test/tb.sv]
// Testbench for the ChaCha double round core: random and directed states checked by a scoreboard.
`timescale 1ns / 1ps

module tb;

   // Eight 64-bit fields; field f holds words 2f (low half) and 2f+1 (high half).
   typedef logic [7:0][63:0] state_type;

   // Expected new states, oldest first, and the check of each rsp transaction.
   class round_scoreboard;
      state_type   expected_states[$];
      int unsigned failures;

      function chdr_pkg::word_type rol(chdr_pkg::word_type x, int unsigned n);
         logic [63:0] twice;
         twice = {x, x};
         return twice[63-n -: 32];
      endfunction

      function void quarter(inout chdr_pkg::word_type a, inout chdr_pkg::word_type b,
                            inout chdr_pkg::word_type c, inout chdr_pkg::word_type d);
         a = a + b; d = rol(d ^ a, 16);
         c = c + d; b = rol(b ^ c, 12);
         a = a + b; d = rol(d ^ a, 8);
         c = c + d; b = rol(b ^ c, 7);
      endfunction

      function state_type double_round(state_type st);
         chdr_pkg::word_type w[16];
         state_type          res;
         for (int i = 0; i < 8; i++) begin
            w[2*i]   = st[i][31:0];
            w[2*i+1] = st[i][63:32];
         end
         // columns
         for (int k = 0; k < 4; k++)
            quarter(w[k], w[4+k], w[8+k], w[12+k]);
         // diagonals
         for (int k = 0; k < 4; k++)
            quarter(w[k], w[4+(k+1)%4], w[8+(k+2)%4], w[12+(k+3)%4]);
         for (int i = 0; i < 8; i++)
            res[i] = {w[2*i+1], w[2*i]};
         return res;
      endfunction

      function void note_request(state_type st);
         expected_states.push_back(double_round(st));
      endfunction

      function void check_response(state_type got);
         state_type want;
         if (expected_states.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected rsp transaction: %h", got);
            return;
         end
         want = expected_states.pop_front();
         for (int f = 0; f < 8; f++) begin
            if (got[f] !== want[f]) begin
               failures++;
               if (failures <= 10)
                  $display("out_words%0d%0d: expected %h, got %h",
                           2*f, 2*f+1, want[f], got[f]);
            end
         end
      endfunction
   endclass

   localparam int unsigned StallLimit = 4000;   // cycles without any transaction
   localparam int unsigned TailCycles = 8;      // pipeline depth plus margin
   localparam int unsigned RandomItems = 1080;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   state_type req_state = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   state_type rsp_state;

   // idle rates in percent, changed per phase
   int unsigned req_gap_pct = 32;
   int unsigned rsp_stall_pct = 79;
   int unsigned idle_cycles = 0;

   round_scoreboard board = new();

   always #10 clock = ~clock;

   chacha20_double_round DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_row0_words01   (req_state[0]),
      .req_row0_words23   (req_state[1]),
      .req_row1_words45   (req_state[2]),
      .req_row1_words67   (req_state[3]),
      .req_row2_words89   (req_state[4]),
      .req_row2_words1011 (req_state[5]),
      .req_row3_words1213 (req_state[6]),
      .req_row3_words1415 (req_state[7]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_words01    (rsp_state[0]),
      .rsp_out_words23    (rsp_state[1]),
      .rsp_out_words45    (rsp_state[2]),
      .rsp_out_words67    (rsp_state[3]),
      .rsp_out_words89    (rsp_state[4]),
      .rsp_out_words1011  (rsp_state[5]),
      .rsp_out_words1213  (rsp_state[6]),
      .rsp_out_words1415  (rsp_state[7])
   );

   // Receiver: checks each rsp transaction and draws the stall for the next cycle.
   // Signals read here at the edge still hold their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_state);
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: any cycle with a transaction on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Drive one state; returns at the edge where the req transaction happens.
   task automatic send_state(input state_type st);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_state <= st;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_request(st);
   endtask

   // Mostly dense random words, with zeros, all-ones and single bits mixed in
   // so that carries out of bit 31 and wraparound show up often.
   function automatic state_type random_state();
      state_type st;
      for (int f = 0; f < 8; f++) begin
         case ($urandom_range(9))
            0: st[f] = '0;
            1: st[f] = '1;
            2: st[f] = {32'hFFFF_FFFF, 32'($urandom)};
            3: st[f] = {32'($urandom), 32'hFFFF_FFFF};
            4: st[f] = 64'd1 << $urandom_range(63);
            default: st[f] = {32'($urandom), 32'($urandom)};
         endcase
      end
      return st;
   endfunction

   // Block until every expected result has been taken.
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_states.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      state_type st;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: zeros, ones, alternating bits, one field at a time
      // all ones or with both MSBs set, and a counter-like state.
      send_state('0);
      send_state('1);
      send_state({8{64'hAAAA_AAAA_AAAA_AAAA}});
      send_state({8{64'h5555_5555_5555_5555}});
      for (int f = 0; f < 8; f++) begin
         st = '0;
         st[f] = '1;
         send_state(st);
      end
      for (int f = 0; f < 8; f++) begin
         st = '0;
         st[f] = 64'h8000_0000_8000_0000;
         send_state(st);
      end
      for (int f = 0; f < 8; f++)
         st[f] = {32'(2*f+1), 32'(2*f)};
      send_state(st);

      // Random phases: sender-light/receiver-heavy idling, the reverse, then none.
      // Sender holds off between phases until the pipeline is empty.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin req_gap_pct = 32; rsp_stall_pct = 79; end
            1: begin req_gap_pct = 79; rsp_stall_pct = 32; end
            default: begin req_gap_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int n = 0; n < RandomItems / 3; n++)
            send_state(random_state());
         drain();
      end

      repeat (TailCycles) @(posedge clock);
      if (board.failures == 0 && board.expected_states.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/chdr_pkg.sv
rtl/core/chacha20_double_round.sv
test/tb.sv
